@@ rtl/servo_bus_packet_framer_core_macros.svh @@
// Assertion macros for the servo bus packet framer.
`ifndef SERVO_BUS_PACKET_FRAMER_CORE_MACROS_SVH
`define SERVO_BUS_PACKET_FRAMER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define SBPF_ASSERT(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("sbpf: check failed");
`define SBPF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sbpf: check failed");
`else
`define SBPF_ASSERT(lbl, clk, rst_n, cond)
`define SBPF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/sbpf_pkg.sv @@
// Types and constants shared by the servo bus packet framer modules.
`default_nettype none
package sbpf_pkg;

	localparam logic       CMD_HEADER   = 1'b0;
	localparam logic       CMD_PARAM    = 1'b1;
	localparam logic [7:0] SYNC_BYTE    = 8'hFF;
	localparam logic [7:0] LENGTH_EXTRA = 8'd2;

	// one queued job: a header or one parameter word, checksum precomputed
	typedef struct packed {
		logic       is_hdr;
		logic       close;
		logic [7:0] b0;     // servo id for a header, parameter byte otherwise
		logic [7:0] len;
		logic [7:0] instr;
		logic [7:0] csum;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic       open;
		logic [7:0] remaining;
	} front_stat_t;

endpackage
`default_nettype wire

@@ rtl/sbpf_front.sv @@
// Front end: accepts words, tracks packet state and checksum, builds jobs.
`default_nettype none
module sbpf_front
	import sbpf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // servo_id, instruction, param_count, param_byte
	input  wire logic        s_tuser,  // cmd
	input  wire q_stat_t     q_stat,
	output logic             push,
	output job_t             job,
	output front_stat_t      stat
);

	logic       open_q;
	logic [7:0] sum_q;
	logic [7:0] rem_q;

	logic       accept;
	logic       is_hdr;
	logic [7:0] servo_id, instruction, param_count, param_byte;
	logic [7:0] len, hdr_sum, par_sum, rem_dec;
	logic       par_close;

	assign servo_id    = s_tdata[7:0];
	assign instruction = s_tdata[15:8];
	assign param_count = s_tdata[23:16];
	assign param_byte  = s_tdata[31:24];

	assign s_tready  = !q_stat.full;
	assign accept    = s_tvalid && s_tready;
	assign is_hdr    = (s_tuser == CMD_HEADER);
	assign len       = param_count + LENGTH_EXTRA;
	assign hdr_sum   = servo_id + len + instruction;
	assign par_sum   = sum_q + param_byte;
	assign rem_dec   = rem_q - 8'd1;
	assign par_close = (rem_dec == 8'd0);

	// stray parameter words are dropped here
	assign push = accept && (is_hdr || open_q);

	always_comb begin
		job.is_hdr = is_hdr;
		job.b0     = is_hdr ? servo_id : param_byte;
		job.len    = len;
		job.instr  = instruction;
		job.close  = is_hdr ? (param_count == 8'd0) : par_close;
		job.csum   = is_hdr ? ~hdr_sum : ~par_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			sum_q  <= '0;
			rem_q  <= '0;
		end else if (push) begin
			if (is_hdr) begin
				sum_q  <= hdr_sum;
				rem_q  <= param_count;
				open_q <= (param_count != 8'd0);
			end else begin
				sum_q  <= par_sum;
				rem_q  <= par_close ? 8'd0 : rem_dec;
				open_q <= !par_close;
			end
		end
	end

	assign stat.open      = open_q;
	assign stat.remaining = rem_q;

endmodule
`default_nettype wire

@@ rtl/sbpf_queue.sv @@
// Short job queue between front and back end; depth must be a power of two.
`default_nettype none
module sbpf_queue
	import sbpf_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	input  wire logic pop,
	output job_t      head,
	output q_stat_t   stat
);

	localparam int AW = $clog2(DEPTH);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head       = mem_q[rd_q];
	assign stat.full  = (cnt_q == (AW+1)'(DEPTH));
	assign stat.empty = (cnt_q == '0);

endmodule
`default_nettype wire

@@ rtl/sbpf_back.sv @@
// Back end: walks the head job out one byte per word into the output register.
`default_nettype none
module sbpf_back
	import sbpf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire job_t       job,
	input  wire q_stat_t    q_stat,
	output logic            pop,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,  // tx_byte
	output logic            m_tlast   // end_of_packet
);

	typedef enum logic [5:0] {
		S_FIRST = 6'b000001,
		S_SYNC2 = 6'b000010,
		S_ID    = 6'b000100,
		S_LEN   = 6'b001000,
		S_INSTR = 6'b010000,
		S_CSUM  = 6'b100000
	} st_t;

	st_t        st_q, st_d;
	logic       vld_q;
	logic [7:0] byte_q, byte_d;
	logic       last_q, last_d;
	logic       load, pop_d;

	assign load = !q_stat.empty && (!vld_q || m_tready);
	assign pop  = load && pop_d;

	always_comb begin
		st_d   = st_q;
		byte_d = '0;
		last_d = 1'b0;
		pop_d  = 1'b0;
		case (st_q)
			S_FIRST: begin
				if (job.is_hdr) begin
					byte_d = SYNC_BYTE;
					st_d   = S_SYNC2;
				end else begin
					byte_d = job.b0;
					if (job.close)
						st_d = S_CSUM;
					else
						pop_d = 1'b1;
				end
			end
			S_SYNC2: begin
				byte_d = SYNC_BYTE;
				st_d   = S_ID;
			end
			S_ID: begin
				byte_d = job.b0;
				st_d   = S_LEN;
			end
			S_LEN: begin
				byte_d = job.len;
				st_d   = S_INSTR;
			end
			S_INSTR: begin
				byte_d = job.instr;
				if (job.close) begin
					st_d = S_CSUM;
				end else begin
					pop_d = 1'b1;
					st_d  = S_FIRST;
				end
			end
			S_CSUM: begin
				byte_d = job.csum;
				last_d = 1'b1;
				pop_d  = 1'b1;
				st_d   = S_FIRST;
			end
			default: st_d = S_FIRST;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_FIRST;
			vld_q <= 1'b0;
		end else begin
			if (load) begin
				st_q  <= st_d;
				vld_q <= 1'b1;
			end else if (m_tready) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= byte_d;
			last_q <= last_d;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = byte_q;
	assign m_tlast  = last_q;

endmodule
`default_nettype wire

@@ rtl/servo_bus_packet_framer_core.sv @@
// Top level of the servo bus packet framer: front end, job queue, back end.
//
//  channel | dir | tdata                                        | tuser | tlast
//  s_      | in  | servo_id, instruction, param_count, param_b. | cmd   | -
//  m_      | out | tx_byte                                      | -     | end_of_packet
//
// The front end takes a word every cycle while the job queue has room.
// The back end sends one byte per cycle through its output register while a
// job is queued and m_tready allows: a header gives FF, FF, id, len, instr,
// a parameter its byte, each plus csum if it closes; stray words give none.
// arst_n clears packet state, queue pointers and the output valid.
// m_tready low holds the output word; the queue then fills and s_tready drops.
`default_nettype none
`include "servo_bus_packet_framer_core_macros.svh"
module servo_bus_packet_framer_core
	import sbpf_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // servo_id, instruction, param_count, param_byte
	input  wire logic        s_tuser,  // cmd
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // tx_byte
	output logic             m_tlast   // end_of_packet
);

	job_t        push_job, head;
	logic        push, pop;
	q_stat_t     q_stat;
	front_stat_t f_stat;

	sbpf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_stat   (q_stat),
		.push     (push),
		.job      (push_job),
		.stat     (f_stat)
	);

	sbpf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	sbpf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	`SBPF_ASSERT_IMPL(a_no_overflow, clk, arst_n, q_stat.full, !push)
	`SBPF_ASSERT_IMPL(a_no_underflow, clk, arst_n, pop, !q_stat.empty)
	`SBPF_ASSERT_IMPL(a_open_has_rem, clk, arst_n, f_stat.open, f_stat.remaining != 8'd0)

endmodule
`default_nettype wire

@@ bench/servo_bus_packet_framer_core_tb.sv @@
// Self-checking testbench for the servo bus packet framer core.
`timescale 1ns / 100ps

module servo_bus_packet_framer_core_tb;
	import sbpf_pkg::*;

	localparam int SETTLE_CYCLES = 12;
	localparam int LONG_HOLD     = 60;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       end_of_packet;
	} bus_byte_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic        s_tuser  = CMD_HEADER;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	// framing state tracked alongside the block
	logic [7:0]  pkt_sum;
	logic [7:0]  pkt_left;
	logic        pkt_open;
	bus_byte_t   tx_bytes_due[$];

	int unsigned words_framed = 0;
	int unsigned error_cnt    = 0;
	int unsigned rx_hold_req  = 0;
	bit          tx_gaps_on   = 1'b1;
	bit          rx_gaps_on   = 1'b1;

	servo_bus_packet_framer_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#500000;
		$display("[servo_bus_packet_framer_core] ERROR");
		$finish;
	end

	function automatic bus_byte_t bus_byte(input logic [7:0] b, input logic eop);
		bus_byte_t w;
		w.tx_byte       = b;
		w.end_of_packet = eop;
		return w;
	endfunction

	task automatic close_frame();
		tx_bytes_due.push_back(bus_byte(~pkt_sum, 1'b1));
		pkt_open = 1'b0;
		pkt_left = '0;
	endtask

	// work out the bus bytes caused by one accepted word
	task automatic frame_word(input logic cmd, input logic [7:0] id, input logic [7:0] instr,
			input logic [7:0] count, input logic [7:0] pbyte);
		logic [7:0] len;
		if (cmd == CMD_HEADER) begin
			len = count + LENGTH_EXTRA;
			tx_bytes_due.push_back(bus_byte(SYNC_BYTE, 1'b0));
			tx_bytes_due.push_back(bus_byte(SYNC_BYTE, 1'b0));
			tx_bytes_due.push_back(bus_byte(id, 1'b0));
			tx_bytes_due.push_back(bus_byte(len, 1'b0));
			tx_bytes_due.push_back(bus_byte(instr, 1'b0));
			pkt_sum  = id + len + instr;
			pkt_left = count;
			pkt_open = 1'b1;
			words_framed++;
			if (count == 8'd0)
				close_frame();
		end else if (pkt_open) begin
			tx_bytes_due.push_back(bus_byte(pbyte, 1'b0));
			pkt_sum  = pkt_sum + pbyte;
			pkt_left = pkt_left - 8'd1;
			words_framed++;
			if (pkt_left == 8'd0)
				close_frame();
		end
	endtask

	task automatic send_word(input logic cmd, input logic [7:0] id, input logic [7:0] instr,
			input logic [7:0] count, input logic [7:0] pbyte);
		if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {pbyte, count, instr, id};
		do @(posedge clk); while (!s_tready);
		frame_word(cmd, id, instr, count, pbyte);
	endtask

	task automatic send_header(input logic [7:0] id, input logic [7:0] instr,
			input logic [7:0] count);
		send_word(CMD_HEADER, id, instr, count, 8'($urandom));
	endtask

	task automatic send_param(input logic [7:0] pbyte);
		send_word(CMD_PARAM, 8'($urandom), 8'($urandom), 8'($urandom), pbyte);
	endtask

	task automatic stop_input();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		stop_input();
		while (tx_bytes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// receiver: ready pattern and result check
	initial begin
		int unsigned low_left;
		bus_byte_t   due;
		low_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (tx_bytes_due.size() == 0) begin
					$error("unexpected word: tx_byte %02h end_of_packet %0b", m_tdata, m_tlast);
					error_cnt++;
				end else begin
					due = tx_bytes_due.pop_front();
					if (m_tdata !== due.tx_byte) begin
						$error("tx_byte: expected %02h, actual %02h", due.tx_byte, m_tdata);
						error_cnt++;
					end
					if (m_tlast !== due.end_of_packet) begin
						$error("end_of_packet: expected %0b, actual %0b",
							due.end_of_packet, m_tlast);
						error_cnt++;
					end
				end
			end
			if (rx_hold_req != 0) begin
				low_left    = rx_hold_req;
				rx_hold_req = 0;
			end else if (low_left == 0 && rx_gaps_on && $urandom_range(0, 3) == 0) begin
				low_left = $urandom_range(1, 6);
			end
			if (low_left != 0) begin
				m_tready <= 1'b0;
				low_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic test_stray_param();
		send_param(8'h00);
		send_param(8'hFF);
	endtask

	task automatic test_zero_count();
		send_header(8'h00, 8'h00, 8'd0);
		send_header(8'hFF, 8'hFF, 8'd0);
	endtask

	task automatic test_field_extremes();
		send_header(8'hFF, 8'hFF, 8'd1);
		send_param(8'hFF);
		send_header(8'hFE, 8'h80, 8'd2);
		send_param(8'h00);
		send_param(8'h80);
	endtask

	task automatic test_abandoned_packet();
		send_header(8'h01, 8'h03, 8'd3);
		send_param(8'h07);
		send_header(8'h02, 8'h04, 8'd0);
		send_param(8'h55);
	endtask

	task automatic test_length_wrap();
		send_header(8'h05, 8'h06, 8'd254);
		send_param(8'h01);
		send_header(8'h05, 8'h06, 8'd255);
		send_param(8'h02);
		send_header(8'h09, 8'h09, 8'd1);
		send_param(8'hAA);
	endtask

	// receiver holds off while a long packet is offered, then the sender waits for the drain
	task automatic test_back_pressure();
		bit saved_gaps;
		saved_gaps  = tx_gaps_on;
		tx_gaps_on  = 1'b0;
		rx_hold_req = LONG_HOLD;
		send_header(8'h11, 8'h03, 8'd12);
		repeat (12) send_param(8'($urandom));
		tx_gaps_on = saved_gaps;
		wait_drained();
	endtask

	task automatic test_random_packets(input int unsigned n_words);
		int unsigned start;
		int unsigned n_par;
		logic [7:0]  id;
		start = words_framed;
		while (words_framed - start < n_words) begin
			id = ($urandom_range(0, 7) == 0) ? 8'hFE : 8'($urandom);
			case ($urandom_range(0, 9))
				0: begin
					send_param(8'($urandom));
				end
				1: begin
					send_header(id, 8'($urandom), 8'($urandom));
					repeat ($urandom_range(0, 3)) send_param(8'($urandom));
				end
				default: begin
					n_par = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24)
						: $urandom_range(0, 6);
					send_header(id, 8'($urandom), 8'(n_par));
					repeat (n_par) send_param(8'($urandom));
				end
			endcase
		end
	endtask

	initial begin
		pkt_sum  = '0;
		pkt_left = '0;
		pkt_open = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_stray_param();
		test_zero_count();
		test_field_extremes();
		test_abandoned_packet();
		test_length_wrap();
		send_param(8'h3C);
		wait_drained();
		test_back_pressure();
		test_random_packets(160);
		wait_drained();
		tx_gaps_on = 1'b0;
		rx_gaps_on = 1'b0;
		test_random_packets(40);
		wait_drained();

		if (error_cnt == 0 && tx_bytes_due.size() == 0)
			$display("[servo_bus_packet_framer_core] OK");
		else
			$display("[servo_bus_packet_framer_core] ERROR");
		$finish;
	end

endmodule
